@@ sv/fss_pkg.sv @@
package fss_pkg;
   localparam int unsigned WordWidth = 32;
   localparam int unsigned ExpWidth  = 8;
   localparam int unsigned FracWidth = 23;
   localparam int unsigned ManWidth  = 24;
   localparam int unsigned SumWidth  = 25;
   localparam int unsigned ShiftWidth = 5;
   localparam int unsigned LzcWidth   = 5;

   typedef logic [WordWidth-1:0] word_type;
   typedef logic [ExpWidth-1:0]  exp_type;

   // stage 1 -> stage 2: aligned operands
   typedef struct packed {
      logic                bypass;
      word_type            bypass_word;
      logic                sa;
      logic                sb;
      exp_type             e;
      logic [ManWidth-1:0] ma;
      logic [ManWidth-1:0] mb;
   } align_type;

   // stage 2 -> stage 3: raw sum or difference
   typedef struct packed {
      logic                bypass;
      word_type            bypass_word;
      logic                s;
      exp_type             e;
      logic                add;
      logic [SumWidth-1:0] m;
   } sum_type;
endpackage

@@ sv/fss_align.sv @@
module fss_align (
   input  logic               clock,
   input  logic               reset,
   input  logic               stall,
   input  logic               in_valid,
   input  fss_pkg::word_type  a_bits,
   input  fss_pkg::word_type  b_bits,
   output logic               out_valid,
   output fss_pkg::align_type out_data
);
   import fss_pkg::*;

   logic      valid_ff;
   align_type data_ff;
   align_type data_in;

   exp_type             ea, eb, ediff;
   logic [ManWidth-1:0] ma, mb;
   logic                a_zero, b_zero, a_less;

   // unpack, detect zeros and align the smaller operand
   always_comb begin
      ea = a_bits[WordWidth-2 -: ExpWidth];
      eb = b_bits[WordWidth-2 -: ExpWidth];
      a_zero = (ea == '0) && (a_bits[FracWidth-1:0] == '0);
      b_zero = (eb == '0) && (b_bits[FracWidth-1:0] == '0);
      ma = {1'b1, a_bits[FracWidth-1:0]};
      mb = {1'b1, b_bits[FracWidth-1:0]};
      a_less = ea < eb;
      ediff = a_less ? (eb - ea) : (ea - eb);
      data_in.bypass = a_zero || b_zero;
      data_in.bypass_word = a_zero ? (b_bits ^ {1'b1, {(WordWidth-1){1'b0}}}) : a_bits;
      data_in.sa = a_bits[WordWidth-1];
      data_in.sb = b_bits[WordWidth-1];
      data_in.e  = a_less ? eb : ea;
      if (ediff >= exp_type'(ManWidth)) begin
         data_in.ma = a_less ? '0 : ma;
         data_in.mb = a_less ? mb : '0;
      end else begin
         data_in.ma = a_less ? (ma >> ediff[ShiftWidth-1:0]) : ma;
         data_in.mb = a_less ? mb : (mb >> ediff[ShiftWidth-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!stall) begin
         valid_ff <= in_valid;
      end
      if (!stall) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

@@ sv/fss_addsub.sv @@
module fss_addsub (
   input  logic               clock,
   input  logic               reset,
   input  logic               stall,
   input  logic               in_valid,
   input  fss_pkg::align_type in_data,
   output logic               out_valid,
   output fss_pkg::sum_type   out_data
);
   import fss_pkg::*;

   logic    valid_ff;
   sum_type data_ff;
   sum_type data_in;
   logic    a_more;

   // add on opposite signs, subtract smaller from larger on equal signs
   always_comb begin
      a_more = in_data.ma > in_data.mb;
      data_in.bypass      = in_data.bypass;
      data_in.bypass_word = in_data.bypass_word;
      data_in.e           = in_data.e;
      data_in.add         = in_data.sa != in_data.sb;
      if (data_in.add) begin
         data_in.s = in_data.sa;
         data_in.m = {1'b0, in_data.ma} + {1'b0, in_data.mb};
      end else if (a_more) begin
         data_in.s = in_data.sa;
         data_in.m = {1'b0, in_data.ma - in_data.mb};
      end else begin
         data_in.s = ~in_data.sb;
         data_in.m = {1'b0, in_data.mb - in_data.ma};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!stall) begin
         valid_ff <= in_valid;
      end
      if (!stall) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

@@ sv/fss_norm.sv @@
module fss_norm (
   input  logic              clock,
   input  logic              reset,
   input  logic              stall,
   input  logic              in_valid,
   input  fss_pkg::sum_type  in_data,
   output logic              out_valid,
   output fss_pkg::word_type out_word
);
   import fss_pkg::*;

   logic                valid_ff;
   word_type            word_ff;
   word_type            word_in;
   logic [LzcWidth-1:0] lz;
   logic [ManWidth-1:0] m, mn;
   exp_type             e;

   // leading zero count over the 24-bit difference
   always_comb begin
      lz = '0;
      for (int i = 0; i < ManWidth; i++) begin
         if (in_data.m[i]) begin
            lz = LzcWidth'(ManWidth - 1 - i);
         end
      end
   end

   // bypass, else carry-fix add or left-normalise sub, then pack
   always_comb begin
      m  = in_data.m[ManWidth-1:0];
      mn = m << lz;
      e  = in_data.e;
      if (in_data.bypass) begin
         word_in = in_data.bypass_word;
      end else if (in_data.add) begin
         if (in_data.m[SumWidth-1]) begin
            word_in = {in_data.s, e + exp_type'(1), in_data.m[FracWidth:1]};
         end else begin
            word_in = {in_data.s, e, in_data.m[FracWidth-1:0]};
         end
      end else if (m == '0) begin
         word_in = '0;
      end else begin
         word_in = {in_data.s, e - exp_type'(lz), mn[FracWidth-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!stall) begin
         valid_ff <= in_valid;
      end
      if (!stall) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;
endmodule

@@ sv/float_single_subtract.sv @@
// Three-stage pipelined single-precision subtract (truncating).
// Throughput: one request per cycle while not stalled; rsp_stall with rsp_valid high freezes every stage.
// Reset (synchronous, active high) clears the stage valid bits only.
module float_single_subtract (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fss_pkg::word_type req_a_bits,
   input  fss_pkg::word_type req_b_bits,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fss_pkg::word_type rsp_diff_bits
);
   import fss_pkg::*;

   logic      v1, v2;
   align_type d1;
   sum_type   d2;
   logic      stall;

   // whole pipe holds while the result is stalled and valid
   assign stall     = rsp_stall && rsp_valid;
   assign req_stall = stall;

   fss_align u_align (
      .clock, .reset, .stall, .in_valid(req_valid),
      .a_bits(req_a_bits), .b_bits(req_b_bits),
      .out_valid(v1), .out_data(d1)
   );

   fss_addsub u_addsub (
      .clock, .reset, .stall, .in_valid(v1), .in_data(d1),
      .out_valid(v2), .out_data(d2)
   );

   fss_norm u_norm (
      .clock, .reset, .stall, .in_valid(v2), .in_data(d2),
      .out_valid(rsp_valid), .out_word(rsp_diff_bits)
   );

   a_hold: assert property (@(posedge clock) disable iff (reset)
      stall |=> $stable(rsp_diff_bits) && rsp_valid)
      else $error("result changed under stall");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      (!stall && req_valid) |-> ##3 rsp_valid || $past(stall) || $past(stall, 2))
      else $error("request lost in pipeline");
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule
